### rtl/core/bbe_pkg.sv
`timescale 1ns / 1ps
package bbe_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int MAX_EDGES    = 4096;
	localparam int VW           = $clog2(MAX_VERTICES);
	localparam int EW           = $clog2(MAX_EDGES);
	localparam int NW           = VW + 1;
	localparam int OFS_W        = 13;
	localparam int DIST_W       = NW;
	localparam int SIGMA_W      = 32;
	localparam int DEP_W        = 48;
	localparam int SUM_W        = 56;
	localparam int SCORE_W      = 48;
	localparam int MD_A_W       = 32;
	localparam int MD_B_W       = 56;
	localparam int MD_C_W       = 37;
	localparam int MD_Q_W       = 48;

	localparam logic [2:0] OP_WR_OFFSET = 3'd0;
	localparam logic [2:0] OP_WR_EDGE   = 3'd1;
	localparam logic [2:0] OP_RUN       = 3'd2;
	localparam logic [2:0] OP_READ      = 3'd3;
	localparam logic [2:0] OP_CLEAR     = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SCORE = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
	localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd1;
	localparam logic [1:0] CFG_NORMALIZE    = 2'd2;

	localparam logic [DIST_W-1:0] UNREACHED = '1;
	localparam logic [MD_B_W-1:0] FIX_ONE   = MD_B_W'(65536);

	typedef struct packed {
		logic [2:0]  operation;
		logic [11:0] index;
		logic [12:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [SCORE_W-1:0] score;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
		logic [MD_C_W-1:0] c;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [MD_Q_W-1:0] q;
		logic              ovf;
	} md_rsp_t;

endpackage

### rtl/core/brandes_betweenness_engine.sv
`timescale 1ns / 1ps
// Offset, edge and unknown requests go straight to the result. Clear sweeps the score store.
// Read uses the shared 88-step divider once, or three times with normalising.
// Run: table set-up over the vertices, then a forward pass over each vertex and its
// edges, a reverse pass over the same, and a divider pass per shortest-path edge.
// After reset the score store is swept to zero over all 1024 entries; no request is
// taken meanwhile. One request at a time.
module brandes_betweenness_engine import bbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [19:0] {
		S_CLR   = 20'h00001,
		S_IDLE  = 20'h00002,
		S_INIT  = 20'h00004,
		S_SEED  = 20'h00008,
		S_POP   = 20'h00010,
		S_VTX   = 20'h00020,
		S_ROW0  = 20'h00040,
		S_ROW1  = 20'h00080,
		S_EDGE  = 20'h00100,
		S_TGT   = 20'h00200,
		S_UPD   = 20'h00400,
		S_TERM  = 20'h00800,
		S_MDW   = 20'h01000,
		S_SUM   = 20'h02000,
		S_CSUM  = 20'h04000,
		S_RDCAP = 20'h08000,
		S_RDM1  = 20'h10000,
		S_RDM2  = 20'h20000,
		S_RDDIV = 20'h40000,
		S_DONE  = 20'h80000
	} state_t;

	state_t state_q;
	logic [NW-1:0]  vc_q;
	logic [15:0]    sc_q;
	logic           norm_q;
	logic [NW-1:0]  cnt_q;
	logic           clr_rsp_q;
	logic [NW-1:0]  head_q;
	logic [NW-1:0]  tail_q;
	logic           rev_q;
	logic [OFS_W-1:0] e_q;
	logic [1:0]     status_q;
	logic           out_valid_q;

	logic [VW-1:0]      s_q;
	logic [VW-1:0]      v_q;
	logic [VW-1:0]      w_q;
	logic [DIST_W-1:0]  dv_q;
	logic [SIGMA_W-1:0] sgv_q;
	logic [DEP_W-1:0]   acc_q;
	logic [OFS_W-1:0]   beg_q;
	logic [OFS_W-1:0]   end_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SCORE_W-1:0] score_q;
	out_item_t          out_data_q;

	logic ro_we; logic [VW:0] ro_wa, ro_ra; logic [OFS_W-1:0] ro_wd, ro_rd;
	logic et_we; logic [EW-1:0] et_wa, et_ra; logic [VW-1:0] et_wd, et_rd;
	logic hd_we; logic [VW-1:0] hd_wa, hd_ra; logic [DIST_W-1:0] hd_wd, hd_rd;
	logic sg_we; logic [VW-1:0] sg_wa, sg_ra; logic [SIGMA_W-1:0] sg_wd, sg_rd;
	logic dp_we; logic [VW-1:0] dp_wa, dp_ra; logic [DEP_W-1:0] dp_wd, dp_rd;
	logic vo_we; logic [VW-1:0] vo_wa, vo_ra; logic [VW-1:0] vo_wd, vo_rd;
	logic cs_we; logic [VW-1:0] cs_wa, cs_ra; logic [SUM_W-1:0] cs_wd, cs_rd;

	md_req_t md_req;
	md_rsp_t md_rsp;

	logic              take;
	logic              load;
	logic [NW-1:0]     n_eff;
	logic [15:0]       den_s;
	logic              norm_on;
	logic [DIST_W-1:0] dv_inc;
	logic [SIGMA_W:0]  sg_sum;
	logic [SIGMA_W-1:0] sg_new;
	logic [SUM_W:0]    cs_sum;
	logic [DEP_W-1:0]  acc_room;
	logic [DEP_W-1:0]  acc_next;
	logic [OFS_W-1:0]  end_cut;
	logic              tgt_out;
	logic              is_pred;

	assign take     = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign load     = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign n_eff    = (vc_q > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vc_q;
	assign den_s    = (sc_q == '0) ? 16'd1 : sc_q;
	assign norm_on  = norm_q && (n_eff > NW'(2));
	assign dv_inc   = dv_q + 1'b1;
	assign sg_sum   = {1'b0, sg_rd} + {1'b0, sgv_q};
	assign sg_new   = sg_sum[SIGMA_W] ? '1 : sg_sum[SIGMA_W-1:0];
	assign cs_sum   = {1'b0, cs_rd} + (SUM_W + 1)'(acc_q);
	assign acc_room = '1 - acc_q;
	assign acc_next = (md_rsp.ovf || md_rsp.q > acc_room) ? '1 : acc_q + md_rsp.q;
	assign end_cut  = (ro_rd > OFS_W'(MAX_EDGES)) ? OFS_W'(MAX_EDGES) : ro_rd;
	assign tgt_out  = {1'b0, et_rd} >= n_eff;
	assign is_pred  = (hd_rd == dv_inc) && (sg_rd != '0);

	always_comb begin
		ro_we = 1'b0; ro_wa = '0; ro_wd = '0; ro_ra = '0;
		et_we = 1'b0; et_wa = '0; et_wd = '0; et_ra = '0;
		hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
		sg_we = 1'b0; sg_wa = '0; sg_wd = '0; sg_ra = '0;
		dp_we = 1'b0; dp_wa = '0; dp_wd = '0; dp_ra = '0;
		vo_we = 1'b0; vo_wa = '0; vo_wd = '0; vo_ra = '0;
		cs_we = 1'b0; cs_wa = '0; cs_wd = '0; cs_ra = '0;
		md_req = '0;
		unique case (state_q)
			S_CLR: begin
				cs_we = 1'b1;
				cs_wa = cnt_q[VW-1:0];
			end
			S_IDLE: begin
				if (take) begin
					unique case (in_data.operation)
						OP_WR_OFFSET: begin
							ro_we = (in_data.index <= 12'(MAX_VERTICES));
							ro_wa = in_data.index[VW:0];
							ro_wd = in_data.value;
						end
						OP_WR_EDGE: begin
							et_we = (in_data.value < 13'(MAX_VERTICES));
							et_wa = in_data.index[EW-1:0];
							et_wd = in_data.value[VW-1:0];
						end
						OP_READ: cs_ra = in_data.index[VW-1:0];
						default: ;
					endcase
				end
			end
			S_INIT: begin
				hd_we = 1'b1; hd_wa = cnt_q[VW-1:0]; hd_wd = UNREACHED;
				sg_we = 1'b1; sg_wa = cnt_q[VW-1:0];
				dp_we = 1'b1; dp_wa = cnt_q[VW-1:0];
			end
			S_SEED: begin
				hd_we = 1'b1; hd_wa = s_q;
				sg_we = 1'b1; sg_wa = s_q; sg_wd = SIGMA_W'(1);
				vo_we = 1'b1; vo_wd = s_q;
			end
			S_POP: vo_ra = rev_q ? VW'(tail_q - 1'b1) : head_q[VW-1:0];
			S_VTX: begin
				ro_ra = {1'b0, vo_rd};
				hd_ra = vo_rd;
				sg_ra = vo_rd;
				dp_ra = vo_rd;
			end
			S_ROW0: ro_ra = {1'b0, v_q} + 1'b1;
			S_EDGE: et_ra = e_q[EW-1:0];
			S_TGT: begin
				hd_ra = et_rd;
				sg_ra = et_rd;
				dp_ra = et_rd;
			end
			S_UPD: begin
				if (hd_rd == UNREACHED) begin
					hd_we = 1'b1; hd_wa = w_q; hd_wd = dv_inc;
					vo_we = (tail_q < n_eff); vo_wa = tail_q[VW-1:0]; vo_wd = w_q;
				end
				if (hd_rd == UNREACHED || hd_rd == dv_inc) begin
					sg_we = 1'b1; sg_wa = w_q; sg_wd = sg_new;
				end
			end
			S_TERM: begin
				md_req.start = is_pred;
				md_req.a     = sgv_q;
				md_req.b     = MD_B_W'(dp_rd) + FIX_ONE;
				md_req.c     = MD_C_W'(sg_rd);
			end
			S_SUM: begin
				dp_we = 1'b1; dp_wa = v_q; dp_wd = acc_q;
				cs_ra = v_q;
			end
			S_CSUM: begin
				cs_we = 1'b1; cs_wa = v_q;
				cs_wd = cs_sum[SUM_W] ? '1 : cs_sum[SUM_W-1:0];
			end
			S_RDCAP: begin
				md_req.start = 1'b1;
				if (norm_on) begin
					md_req.a = MD_A_W'(n_eff - 1'b1);
					md_req.b = MD_B_W'(n_eff - NW'(2));
					md_req.c = MD_C_W'(1);
				end else begin
					md_req.a = MD_A_W'(1);
					md_req.b = cs_rd;
					md_req.c = MD_C_W'(den_s);
				end
			end
			S_RDM1: begin
				md_req.start = md_rsp.done;
				md_req.a     = md_rsp.q[MD_A_W-1:0];
				md_req.b     = MD_B_W'(den_s);
				md_req.c     = MD_C_W'(1);
			end
			S_RDM2: begin
				md_req.start = md_rsp.done;
				md_req.a     = MD_A_W'(1);
				md_req.b     = sum_q;
				md_req.c     = md_rsp.q[MD_C_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q   <= '0;
			sc_q   <= 16'd1;
			norm_q <= 1'b0;
		end else if (cfg_write) begin
			priority case (cfg_index)
				CFG_VERTEX_COUNT: vc_q   <= cfg_data[NW-1:0];
				CFG_SAMPLE_COUNT: sc_q   <= cfg_data;
				CFG_NORMALIZE:    norm_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			clr_rsp_q   <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			rev_q       <= 1'b0;
			e_q         <= '0;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[VW-1:0] == '1) begin
						cnt_q    <= '0;
						status_q <= ST_OK;
						state_q  <= clr_rsp_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						status_q <= ST_OK;
						state_q  <= S_DONE;
						unique case (in_data.operation)
							OP_WR_OFFSET: begin
								if (in_data.index > 12'(MAX_VERTICES)) status_q <= ST_RANGE;
							end
							OP_WR_EDGE: begin
								if (in_data.value >= 13'(MAX_VERTICES)) status_q <= ST_RANGE;
							end
							OP_RUN: begin
								if (in_data.index >= 12'(n_eff)) status_q <= ST_RANGE;
								else begin
									cnt_q   <= '0;
									state_q <= S_INIT;
								end
							end
							OP_READ: begin
								if (in_data.index >= 12'(n_eff)) status_q <= ST_RANGE;
								else state_q <= S_RDCAP;
							end
							OP_CLEAR: begin
								cnt_q     <= '0;
								clr_rsp_q <= 1'b1;
								state_q   <= S_CLR;
							end
							default: ;
						endcase
					end
				end
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == n_eff - 1'b1) state_q <= S_SEED;
				end
				S_SEED: begin
					head_q  <= '0;
					tail_q  <= NW'(1);
					rev_q   <= 1'b0;
					state_q <= S_POP;
				end
				S_POP: begin
					if (!rev_q) begin
						if (head_q == tail_q) rev_q <= 1'b1;
						else begin
							head_q  <= head_q + 1'b1;
							state_q <= S_VTX;
						end
					end else if (tail_q == '0) begin
						status_q <= ST_OK;
						state_q  <= S_DONE;
					end else begin
						tail_q  <= tail_q - 1'b1;
						state_q <= S_VTX;
					end
				end
				S_VTX:  state_q <= S_ROW0;
				S_ROW0: state_q <= S_ROW1;
				S_ROW1: begin
					e_q     <= (beg_q > end_cut) ? end_cut : beg_q;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					if (e_q == end_q) state_q <= rev_q ? S_SUM : S_POP;
					else state_q <= S_TGT;
				end
				S_TGT: begin
					if (tgt_out) begin
						e_q     <= e_q + 1'b1;
						state_q <= S_EDGE;
					end else begin
						state_q <= rev_q ? S_TERM : S_UPD;
					end
				end
				S_UPD: begin
					if (hd_rd == UNREACHED && tail_q < n_eff) tail_q <= tail_q + 1'b1;
					e_q     <= e_q + 1'b1;
					state_q <= S_EDGE;
				end
				S_TERM: begin
					if (is_pred) state_q <= S_MDW;
					else begin
						e_q     <= e_q + 1'b1;
						state_q <= S_EDGE;
					end
				end
				S_MDW: begin
					if (md_rsp.done) begin
						e_q     <= e_q + 1'b1;
						state_q <= S_EDGE;
					end
				end
				S_SUM:  state_q <= (v_q != s_q) ? S_CSUM : S_POP;
				S_CSUM: state_q <= S_POP;
				S_RDCAP: state_q <= norm_on ? S_RDM1 : S_RDDIV;
				S_RDM1: begin
					if (md_rsp.done) state_q <= S_RDM2;
				end
				S_RDM2: begin
					if (md_rsp.done) state_q <= S_RDDIV;
				end
				S_RDDIV: begin
					if (md_rsp.done) begin
						status_q <= ST_SCORE;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (load) begin
						clr_rsp_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s_q     <= in_data.index[VW-1:0];
			score_q <= '0;
		end
		if (state_q == S_VTX) v_q <= vo_rd;
		if (state_q == S_ROW0) begin
			beg_q <= ro_rd;
			dv_q  <= hd_rd;
			sgv_q <= sg_rd;
			acc_q <= dp_rd;
		end
		if (state_q == S_ROW1) end_q <= end_cut;
		if (state_q == S_TGT) w_q <= et_rd;
		if (state_q == S_MDW && md_rsp.done) acc_q <= acc_next;
		if (state_q == S_RDCAP) sum_q <= cs_rd;
		if (state_q == S_RDDIV && md_rsp.done) begin
			score_q <= md_rsp.ovf ? '1 : md_rsp.q;
		end
		if (load) begin
			out_data_q.status <= status_q;
			out_data_q.score  <= score_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	bbe_ram #(.W(OFS_W), .D(MAX_VERTICES + 1)) u_row_offsets (
		.clk(clk), .we(ro_we), .waddr(ro_wa), .wdata(ro_wd), .raddr(ro_ra), .rdata(ro_rd)
	);

	bbe_ram #(.W(VW), .D(MAX_EDGES)) u_edge_targets (
		.clk(clk), .we(et_we), .waddr(et_wa), .wdata(et_wd), .raddr(et_ra), .rdata(et_rd)
	);

	bbe_ram #(.W(DIST_W), .D(MAX_VERTICES)) u_hop_distance (
		.clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd)
	);

	bbe_ram #(.W(SIGMA_W), .D(MAX_VERTICES)) u_path_counts (
		.clk(clk), .we(sg_we), .waddr(sg_wa), .wdata(sg_wd), .raddr(sg_ra), .rdata(sg_rd)
	);

	bbe_ram #(.W(DEP_W), .D(MAX_VERTICES)) u_dependency (
		.clk(clk), .we(dp_we), .waddr(dp_wa), .wdata(dp_wd), .raddr(dp_ra), .rdata(dp_rd)
	);

	bbe_ram #(.W(VW), .D(MAX_VERTICES)) u_visit_order (
		.clk(clk), .we(vo_we), .waddr(vo_wa), .wdata(vo_wd), .raddr(vo_ra), .rdata(vo_rd)
	);

	bbe_ram #(.W(SUM_W), .D(MAX_VERTICES)) u_centrality_sum (
		.clk(clk), .we(cs_we), .waddr(cs_wa), .wdata(cs_wd), .raddr(cs_ra), .rdata(cs_rd)
	);

	bbe_muldiv u_muldiv (
		.clk(clk), .arst_n(arst_n), .req(md_req), .rsp(md_rsp)
	);

endmodule

### rtl/core/bbe_ram.sv
`timescale 1ns / 1ps
module bbe_ram #(
	parameter int W = 8,
	parameter int D = 2,
	localparam int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/bbe_muldiv.sv
`timescale 1ns / 1ps
module bbe_muldiv import bbe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	localparam int HALF_W = MD_B_W / 2;
	localparam int PROD_W = MD_A_W + MD_B_W;
	localparam int CNT_W  = $clog2(PROD_W);

	typedef enum logic [3:0] {
		MD_IDLE = 4'b0001,
		MD_LO   = 4'b0010,
		MD_HI   = 4'b0100,
		MD_DIV  = 4'b1000
	} md_phase_t;

	md_phase_t            phase_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [MD_A_W-1:0]    a_q;
	logic [MD_B_W-1:0]    b_q;
	logic [MD_C_W-1:0]    c_q;
	logic [PROD_W-1:0]    prod_q;
	logic [MD_C_W:0]      rem_q;
	logic [MD_Q_W-1:0]    quo_q;
	logic                 ovf_q;
	logic [MD_A_W+HALF_W-1:0] mul_p;
	logic [MD_C_W:0]      trial;
	logic                 fits;

	assign mul_p = a_q * ((phase_q == MD_HI) ? b_q[MD_B_W-1:HALF_W] : b_q[HALF_W-1:0]);
	assign trial = {rem_q[MD_C_W-1:0], prod_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, c_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				MD_IDLE: begin
					if (req.start) phase_q <= MD_LO;
				end
				MD_LO: phase_q <= MD_HI;
				MD_HI: begin
					phase_q <= MD_DIV;
					cnt_q   <= CNT_W'(PROD_W - 1);
				end
				MD_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						phase_q <= MD_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= MD_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			MD_IDLE: begin
				if (req.start) begin
					a_q   <= req.a;
					b_q   <= req.b;
					c_q   <= req.c;
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			MD_LO: prod_q <= PROD_W'(mul_p);
			MD_HI: prod_q <= prod_q + {mul_p, HALF_W'(0)};
			MD_DIV: begin
				prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				rem_q  <= fits ? trial - {1'b0, c_q} : trial;
				quo_q  <= {quo_q[MD_Q_W-2:0], fits};
				ovf_q  <= ovf_q | quo_q[MD_Q_W-1];
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.q    = quo_q;
	assign rsp.ovf  = ovf_q;

endmodule
